// ===== rtl/tcg_pkg.sv =====
// ---------------------------------------------------------------------------
// tcg_pkg: shared types and constants
// sequencer states, register indexes and tempo limits for the tempo clock
// generator
// ---------------------------------------------------------------------------
package tcg_pkg;

  // dividend width of the tempo division, sample_rate * 15360 fits in it
  localparam int NUM_W = 32;

  // tempo window in q.8 bpm: 20 bpm and 400 bpm
  localparam logic [NUM_W-1:0] TEMPO_MIN = 32'd5120;
  localparam logic [NUM_W-1:0] TEMPO_MAX = 32'd102400;

  localparam int TEMPO_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_SAMPLE_RATE   = 3'd1,
    REG_TRIG_HIGH     = 3'd2,
    REG_TRIG_LOW      = 3'd3,
    REG_PULSE_LEN     = 3'd4,
    REG_RESET_LEN     = 3'd5,
    REG_LIGHT_LEN     = 3'd6
  } cfg_reg_t;

  // pulse counter slots
  localparam int PG_CLOCK = 0;
  localparam int PG_DIV2  = 1;
  localparam int PG_MULT2 = 2;
  localparam int PG_RESET = 3;
  localparam int PG_LAMP  = 4;
  localparam int PG_NUM   = 5;

  // tick sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGES,
    S_DIV_TEMPO,
    S_DIV_SMOOTH,
    S_TIMING
  } seq_state_t;

endpackage

// ===== rtl/tcg_div.sv =====
// ---------------------------------------------------------------------------
// tcg_div: iterative divider
// restoring unsigned division, one quotient bit per cycle, registered result
// ---------------------------------------------------------------------------
module tcg_div #(
  parameter int NW = 32,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] shreg;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [CW-1:0] count;
  logic          running;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, shreg[NW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CW'(NW);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dsr   <= divisor;
      rem   <= '0;
    end else if (running) begin
      shreg <= {shreg[NW-2:0], fits};
      rem   <= fits ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
    end
  end

  assign quotient  = shreg;
  assign remainder = rem;

endmodule

// ===== rtl/tempo_clock_generator_with_sync_top.sv =====
// ---------------------------------------------------------------------------
// tempo_clock_generator_with_sync_top: tempo clock generator with sync
// internal phase accumulator clock or measured external clock, with div2,
// x2, reset and lamp pulse outputs, one result word per tick word
// ---------------------------------------------------------------------------
//  channel  handshake          payload
//  in       in_valid/in_stall  run_button reset_button reset_voltage
//                              ext_connected ext_voltage
//  out      out_valid/out_stall clock_gate div2_gate mult2_gate reset_gate
//                              clock_lamp is_running tempo_valid measured_tempo
//  cfg      cfg_valid/cfg_ready cfg_index cfg_data
//
//  a tick word passes the edge and timing steps, plus the tempo division when an
//  external edge is measured and the smoothing step when the tempo is smoothed;
//  the divider gives one bit per cycle; 1/5 smoothing is a reciprocal multiply
//  in_stall is high from the cycle after acceptance until the result is in
//  the output register
//  the output register holds one result; a stalled output holds the sequencer
//  in its last step. rst is synchronous and restores the register defaults
// ---------------------------------------------------------------------------
module tempo_clock_generator_with_sync_top #(
  parameter int PHASE_BITS = 32,
  parameter int COUNT_BITS = 32,
  parameter int PULSE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          run_button,
  input  logic                          reset_button,
  input  logic signed [15:0]            reset_voltage,
  input  logic                          ext_connected,
  input  logic signed [15:0]            ext_voltage,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          clock_gate,
  output logic                          div2_gate,
  output logic                          mult2_gate,
  output logic                          reset_gate,
  output logic                          clock_lamp,
  output logic                          is_running,
  output logic                          tempo_valid,
  output logic [tcg_pkg::TEMPO_W-1:0]   measured_tempo,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tcg_pkg::*;

  localparam logic [31:0] PMAX = 32'((64'd1 << PULSE_BITS) - 64'd1);

  // x/5 for x below 2^18 as (x * 52429) >> 18
  localparam logic [15:0] RECIP5 = 16'd52429;

  // configuration registers
  logic [31:0]        phase_step;
  logic [17:0]        sample_rate;
  logic signed [15:0] trig_high;
  logic signed [15:0] trig_low;
  logic [15:0]        pulse_len;
  logic [15:0]        reset_len;
  logic [15:0]        light_len;

  // captured tick word
  logic               t_run, t_rstb, t_ext;
  logic signed [15:0] t_rstv, t_extv;

  // block state
  seq_state_t               state, state_next;
  logic                     run_state, mode_ext, div2_tog, seen_edge, tempo_ok;
  logic [PHASE_BITS-1:0]    phase_acc;
  logic [COUNT_BITS-1:0]    ticks, edge_period, half_cnt;
  logic                     half_act;
  logic [TEMPO_W-1:0]       tempo;
  logic [3:0]               lvl;
  logic [PULSE_BITS-1:0]    pcnt [PG_NUM];
  logic                     ext_edge;
  logic                     smooth_neg;
  logic [TEMPO_W-1:0]       s_mag_r;

  function automatic logic [PULSE_BITS-1:0] sat_len(input logic [15:0] len);
    logic [31:0] l32;
    l32 = {16'd0, len};
    return (l32 > PMAX) ? PMAX[PULSE_BITS-1:0] : l32[PULSE_BITS-1:0];
  endfunction

  function automatic logic [PULSE_BITS-1:0] pmax(input logic [PULSE_BITS-1:0] a,
                                                 input logic [PULSE_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= 32'd178957;
      sample_rate <= 18'd48000;
      trig_high   <= 16'sd1000;
      trig_low    <= 16'sd0;
      pulse_len   <= 16'd48;
      reset_len   <= 16'd480;
      light_len   <= 16'd1920;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_STEP:  phase_step  <= cfg_data;
        REG_SAMPLE_RATE: sample_rate <= cfg_data[17:0];
        REG_TRIG_HIGH:   trig_high   <= cfg_data[15:0];
        REG_TRIG_LOW:    trig_low    <= cfg_data[15:0];
        REG_PULSE_LEN:   pulse_len   <= cfg_data[15:0];
        REG_RESET_LEN:   reset_len   <= cfg_data[15:0];
        REG_LIGHT_LEN:   light_len   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      t_run  <= run_button;
      t_rstb <= reset_button;
      t_rstv <= reset_voltage;
      t_ext  <= ext_connected;
      t_extv <= ext_voltage;
    end
  end

  // ---- edge step: buttons, triggers, mode change, tick count
  logic                  a_run_rise, a_rst_rise, a_rstv_rise, a_rstv_lvl;
  logic                  a_mode_chg, a_clr, a_run, a_ext_lvl_in, a_ext_lvl;
  logic                  a_ext_edge, a_measure, a_seen;
  logic [COUNT_BITS-1:0] a_ticks_base, a_ticks;

  always_comb begin
    a_run_rise = t_run & ~lvl[0];
    a_rst_rise = t_rstb & ~lvl[1];
    a_rstv_rise = 1'b0;
    a_rstv_lvl = lvl[2];
    if (lvl[2]) begin
      if (t_rstv <= trig_low) a_rstv_lvl = 1'b0;
    end else if (t_rstv >= trig_high) begin
      a_rstv_lvl  = 1'b1;
      a_rstv_rise = 1'b1;
    end
    a_run      = run_state ^ a_run_rise;
    a_mode_chg = (t_ext != mode_ext);
    a_clr      = a_run_rise | a_rst_rise | a_rstv_rise | a_mode_chg;
    a_ext_lvl_in = a_mode_chg ? 1'b0 : lvl[3];
    a_seen       = a_mode_chg ? 1'b0 : seen_edge;
    a_ticks_base = a_mode_chg ? '0 : ticks;
    a_ticks    = a_ticks_base;
    a_ext_lvl  = a_ext_lvl_in;
    a_ext_edge = 1'b0;
    if (t_ext) begin
      if (a_ticks_base != '1) a_ticks = a_ticks_base + 1'b1;
      if (a_ext_lvl_in) begin
        if (t_extv <= trig_low) a_ext_lvl = 1'b0;
      end else if (t_extv >= trig_high) begin
        a_ext_lvl  = 1'b1;
        a_ext_edge = 1'b1;
      end
    end
    a_measure = a_ext_edge && a_seen && (a_ticks > COUNT_BITS'(1));
  end

  // ---- divider: tempo quotient; 1/5 smoothing by reciprocal multiply
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_dvd, div_quo;
  logic [COUNT_BITS-1:0] div_dsr, div_rem;
  logic [NUM_W-1:0]      tempo_num;
  logic                  q_ok;
  logic [TEMPO_W:0]      s_diff;
  logic [TEMPO_W-1:0]    s_mag;
  logic [TEMPO_W+15:0]   s_prod;
  logic [TEMPO_W-1:0]    s_step;

  assign tempo_num = NUM_W'({sample_rate, 14'd0}) - NUM_W'({sample_rate, 10'd0});
  assign q_ok = (div_quo >= TEMPO_MIN) && (div_quo <= TEMPO_MAX) &&
                !(div_quo == TEMPO_MAX && div_rem != '0);
  assign s_diff = {1'b0, div_quo[TEMPO_W-1:0]} - {1'b0, tempo};
  assign s_mag  = s_diff[TEMPO_W] ? TEMPO_W'(-s_diff) : s_diff[TEMPO_W-1:0];
  assign s_prod = {16'd0, s_mag_r} * {{TEMPO_W{1'b0}}, RECIP5};
  assign s_step = {2'b00, s_prod[TEMPO_W+15:18]};

  always_comb begin
    div_start = 1'b0;
    div_dvd   = tempo_num;
    div_dsr   = a_ticks;
    if (state == S_EDGES && a_measure) div_start = 1'b1;
  end

  tcg_div #(.NW(NUM_W), .DW(COUNT_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // ---- timing step: clocks, x2, phase, pulse counters
  logic                  out_free;
  logic                  b_run_clk, b_mult2, b_div2_tog_n, b_fire_div2;
  logic [COUNT_BITS-1:0] b_ticks, b_half;
  logic                  b_half_act, b_seen, b_timeout;
  logic [PHASE_BITS:0]   b_sum;
  logic [PHASE_BITS-1:0] b_phase, b_step;
  logic [47:0]           step48;
  logic [PULSE_BITS-1:0] b_cnt [PG_NUM];
  logic [PG_NUM-1:0]     b_gate;
  logic [PULSE_BITS-1:0] len_p, len_l;

  assign out_free = !(out_valid && out_stall);
  assign step48   = {16'd0, phase_step};
  assign b_step   = step48[PHASE_BITS-1:0];
  assign len_p    = sat_len(pulse_len);
  assign len_l    = sat_len(light_len);

  always_comb begin
    b_run_clk  = 1'b0;
    b_mult2    = 1'b0;
    b_ticks    = ticks;
    b_half     = half_cnt;
    b_half_act = half_act;
    b_seen     = seen_edge;
    b_phase    = phase_acc;
    b_sum      = {1'b0, phase_acc} + {1'b0, b_step};
    b_timeout  = 1'b0;
    if (mode_ext) begin
      if (ext_edge) begin
        b_seen  = 1'b1;
        b_ticks = '0;
        if (run_state) begin
          b_run_clk = 1'b1;
          if (edge_period > COUNT_BITS'(2)) begin
            b_half     = edge_period >> 1;
            b_half_act = 1'b1;
          end
        end
      end
      if (run_state && b_half_act) begin
        if (b_half == '0) begin
          b_mult2    = 1'b1;
          b_half_act = 1'b0;
        end else begin
          b_half = b_half - 1'b1;
        end
      end
      b_timeout = (edge_period != '0) &&
                  ({3'b000, b_ticks} > {edge_period, 3'b000});
    end else if (run_state) begin
      b_mult2   = (b_sum[PHASE_BITS] | b_sum[PHASE_BITS-1]) & ~phase_acc[PHASE_BITS-1];
      b_phase   = b_sum[PHASE_BITS-1:0];
      b_run_clk = b_sum[PHASE_BITS];
    end
    b_fire_div2  = b_run_clk & ~div2_tog;
    b_div2_tog_n = div2_tog ^ b_run_clk;

    for (int i = 0; i < PG_NUM; i++) b_cnt[i] = pcnt[i];
    if (b_run_clk) begin
      b_cnt[PG_CLOCK] = pmax(b_cnt[PG_CLOCK], len_p);
      b_cnt[PG_MULT2] = pmax(b_cnt[PG_MULT2], len_p);
      b_cnt[PG_LAMP]  = pmax(b_cnt[PG_LAMP], len_l);
    end
    if (b_fire_div2) b_cnt[PG_DIV2] = pmax(b_cnt[PG_DIV2], len_p);
    if (b_mult2) b_cnt[PG_MULT2] = pmax(b_cnt[PG_MULT2], len_p);
    for (int i = 0; i < PG_NUM; i++) begin
      b_gate[i] = (b_cnt[i] != '0);
      if (b_gate[i]) b_cnt[i] = b_cnt[i] - 1'b1;
    end
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_valid) state_next = S_EDGES;
      S_EDGES:      state_next = a_measure ? S_DIV_TEMPO : S_TIMING;
      S_DIV_TEMPO:  if (div_done) state_next = (q_ok && tempo_ok) ? S_DIV_SMOOTH : S_TIMING;
      S_DIV_SMOOTH: state_next = S_TIMING;
      S_TIMING:     if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // ---- state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      run_state   <= 1'b1;
      mode_ext    <= 1'b0;
      div2_tog    <= 1'b0;
      seen_edge   <= 1'b0;
      tempo_ok    <= 1'b0;
      phase_acc   <= '0;
      ticks       <= '0;
      edge_period <= '0;
      half_cnt    <= '0;
      half_act    <= 1'b0;
      tempo       <= '0;
      lvl         <= '0;
      ext_edge    <= 1'b0;
      smooth_neg  <= 1'b0;
      s_mag_r     <= '0;
      out_valid   <= 1'b0;
      for (int i = 0; i < PG_NUM; i++) pcnt[i] <= '0;
    end else begin
      // result register: loaded at the end of the timing step, emptied on take
      if (state == S_TIMING && out_free) out_valid <= 1'b1;
      else if (!out_stall)               out_valid <= 1'b0;
      unique case (state)
        S_EDGES: begin
          lvl       <= {a_ext_lvl, a_rstv_lvl, t_rstb, t_run};
          run_state <= a_run;
          mode_ext  <= t_ext;
          ticks     <= a_ticks;
          seen_edge <= a_seen;
          ext_edge  <= a_ext_edge;
          if (a_mode_chg) begin
            edge_period <= '0;
            tempo       <= '0;
            tempo_ok    <= 1'b0;
          end
          if (a_measure) edge_period <= a_ticks;
          if (a_clr) begin
            phase_acc      <= '0;
            div2_tog       <= 1'b0;
            half_act       <= 1'b0;
            pcnt[PG_CLOCK] <= '0;
            pcnt[PG_DIV2]  <= '0;
            pcnt[PG_MULT2] <= '0;
          end
          if (a_rst_rise || a_rstv_rise)
            pcnt[PG_RESET] <= pmax(pcnt[PG_RESET], sat_len(reset_len));
        end
        S_DIV_TEMPO: begin
          if (div_done && q_ok) begin
            smooth_neg <= s_diff[TEMPO_W];
            s_mag_r    <= s_mag;
            if (!tempo_ok) begin
              tempo    <= div_quo[TEMPO_W-1:0];
              tempo_ok <= 1'b1;
            end
          end
        end
        S_DIV_SMOOTH: begin
          tempo <= smooth_neg ? tempo - s_step : tempo + s_step;
        end
        S_TIMING: begin
          if (out_free) begin
            seen_edge <= b_seen;
            ticks     <= b_ticks;
            half_cnt  <= b_half;
            half_act  <= b_half_act;
            phase_acc <= b_phase;
            div2_tog  <= b_div2_tog_n;
            for (int i = 0; i < PG_NUM; i++) pcnt[i] <= b_cnt[i];
            if (b_timeout) begin
              tempo_ok <= 1'b0;
              tempo    <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_TIMING && out_free) begin
      clock_gate     <= b_gate[PG_CLOCK];
      div2_gate      <= b_gate[PG_DIV2];
      mult2_gate     <= b_gate[PG_MULT2];
      reset_gate     <= b_gate[PG_RESET];
      clock_lamp     <= b_gate[PG_LAMP];
      is_running     <= run_state;
      tempo_valid    <= tempo_ok & ~b_timeout;
      measured_tempo <= b_timeout ? '0 : tempo;
    end
  end

endmodule
